### sv/lrpb_pkg.sv
`default_nettype none

package lrpb_pkg;

	localparam int DISPLAY_COLUMNS_DEF = 128;
	localparam int DISPLAY_ROWS_DEF    = 64;
	localparam int PAGE_HEIGHT         = 8;

	typedef enum logic [1:0] {
		CMD_DRAW  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_LINE,
		ST_DRAIN,
		ST_READ,
		ST_CLEAR,
		ST_RESULT
	} st_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic clr_en;
		logic rd_en;
		logic res_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic skip;
		logic last;
		logic pipe_busy;
		logic clr_last;
	} dp_stat_t;

endpackage

`default_nettype wire

### sv/lrpb_ram.sv
`default_nettype none

module lrpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/lrpb_ctrl.sv
`default_nettype none

module lrpb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output lrpb_pkg::dp_cmd_t  cmd,
	input  lrpb_pkg::dp_stat_t stat
);

	import lrpb_pkg::*;

	st_t  state_q;
	st_t  state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.cmd)
					CMD_DRAW:  state_d = stat.skip ? ST_RESULT : ST_LINE;
					CMD_READ:  state_d = ST_READ;
					CMD_CLEAR: state_d = ST_CLEAR;
					default:   state_d = ST_RESULT;
				endcase
			end
			ST_LINE: begin
				if (stat.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_READ: begin
				state_d = ST_RESULT;
			end
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.clr_en = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_LINE: begin
				cmd.step = 1'b1;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			ST_RESULT: begin
				cmd.res_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.pipe_busy)
		else $error("pixel pipeline still busy while a new beat can be taken");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DECODE))
		else $error("accepted beat was not decoded in the next cycle");

	a_result_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!stat.pipe_busy && !cmd.step && !cmd.clr_en))
		else $error("result loaded before the buffer writes were finished");

endmodule

`default_nettype wire

### sv/lrpb_datapath.sv
`default_nettype none

module lrpb_datapath #(
	parameter int DISPLAY_COLUMNS = lrpb_pkg::DISPLAY_COLUMNS_DEF,
	parameter int DISPLAY_ROWS    = lrpb_pkg::DISPLAY_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lrpb_pkg::dp_cmd_t  cmd,
	output lrpb_pkg::dp_stat_t stat,
	input  logic [1:0]         command,
	input  logic [7:0]         start_x,
	input  logic [7:0]         start_y,
	input  logic [7:0]         end_x,
	input  logic [7:0]         end_y,
	input  logic [9:0]         byte_address,
	output logic [7:0]         read_data,
	output logic               line_skipped
);

	import lrpb_pkg::*;

	localparam int PAGES        = (DISPLAY_ROWS + PAGE_HEIGHT - 1) / PAGE_HEIGHT;
	localparam int BUFFER_BYTES = PAGES * DISPLAY_COLUMNS;
	localparam int AW           = $clog2(BUFFER_BYTES);
	localparam logic [8:0]    COLS_W    = 9'(DISPLAY_COLUMNS);
	localparam logic [8:0]    ROWS_W    = 9'(DISPLAY_ROWS);
	localparam logic [13:0]   BYTES_W   = 14'(BUFFER_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);

	// Latched command.
	cmd_t          cmd_q;
	logic          skip_q;
	logic          rd_ok_q;
	logic [AW-1:0] raddr_q;

	// Line walk.
	logic [7:0] x_q;
	logic [7:0] y_q;
	logic [8:0] acc_q;
	logic [7:0] major_q;
	logic [7:0] minor_q;
	logic [7:0] cnt_q;
	logic       xmaj_q;
	logic       xneg_q;
	logic       yneg_q;

	// Pixel read-modify-write pipeline.
	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mask_s1;
	logic          valid_s2;
	logic [AW-1:0] addr_s2;
	logic [7:0]    mask_s2;
	logic          wen_q;
	logic [AW-1:0] waddr_q;
	logic [7:0]    wdata_q;

	logic [AW-1:0] clr_q;
	logic [7:0]    rdata_q;
	logic          skip_out_q;

	logic [7:0]    dx;
	logic [7:0]    dy;
	logic          ld_xmaj;
	logic [7:0]    ld_major;
	logic [7:0]    ld_minor;
	logic          ld_skip;
	logic          ld_rd_ok;
	logic [8:0]    acc_sum;
	logic          acc_wrap;
	logic [8:0]    acc_nx;
	logic          x_mv;
	logic          y_mv;
	logic          pix_on;
	logic [13:0]   pix_idx;
	logic [7:0]    pix_mask;
	logic [7:0]    merged;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	always_comb begin
		dx       = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
		dy       = (end_y >= start_y) ? end_y - start_y : start_y - end_y;
		ld_xmaj  = dx >= dy;
		ld_major = ld_xmaj ? dx : dy;
		ld_minor = ld_xmaj ? dy : dx;
		// A start point equal to the width or height is still drawn.
		ld_skip  = ({1'b0, start_x} > COLS_W) || ({1'b0, start_y} > ROWS_W);
		ld_rd_ok = 14'(byte_address) < BYTES_W;
	end

	always_comb begin
		acc_sum  = acc_q + {1'b0, minor_q};
		acc_wrap = acc_sum >= {1'b0, major_q};
		acc_nx   = acc_wrap ? acc_sum - {1'b0, major_q} : acc_sum;
		x_mv     = xmaj_q | acc_wrap;
		y_mv     = !xmaj_q | acc_wrap;
		pix_on   = ({1'b0, x_q} < COLS_W) && ({1'b0, y_q} < ROWS_W);
		pix_idx  = 14'(y_q[7:3]) * 14'(COLS_W) + 14'(x_q);
		pix_mask = 8'd1 << y_q[2:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= cmd_t'(command);
			skip_q  <= ld_skip;
			rd_ok_q <= ld_rd_ok;
			raddr_q <= AW'(byte_address);
			x_q     <= start_x;
			y_q     <= start_y;
			acc_q   <= {2'b00, ld_major[7:1]};
			major_q <= ld_major;
			minor_q <= ld_minor;
			cnt_q   <= ld_major;
			xmaj_q  <= ld_xmaj;
			xneg_q  <= end_x < start_x;
			yneg_q  <= end_y < start_y;
		end else if (cmd.step) begin
			acc_q <= acc_nx;
			cnt_q <= cnt_q - 8'd1;
			if (x_mv) begin
				x_q <= xneg_q ? x_q - 8'd1 : x_q + 8'd1;
			end
			if (y_mv) begin
				y_q <= yneg_q ? y_q - 8'd1 : y_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= pix_idx[AW-1:0];
		mask_s1 <= pix_mask;
		addr_s2 <= addr_s1;
		mask_s2 <= mask_s1;
		waddr_q <= addr_s2;
		wdata_q <= merged;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			wen_q    <= 1'b0;
		end else begin
			valid_s1 <= cmd.step && pix_on;
			valid_s2 <= valid_s1;
			wen_q    <= valid_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
		end
	end

	// The byte written in the previous cycle is not yet in the read data, so it is forwarded.
	assign merged = (((wen_q && (waddr_q == addr_s2)) ? wdata_q : ram_rdata) | mask_s2);

	always_comb begin
		ram_we    = valid_s2 || cmd.clr_en;
		ram_waddr = cmd.clr_en ? clr_q : addr_s2;
		ram_wdata = cmd.clr_en ? 8'd0 : merged;
		ram_re    = valid_s1 || cmd.rd_en;
		ram_raddr = cmd.rd_en ? raddr_q : addr_s1;
	end

	lrpb_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rdata_q    <= ((cmd_q == CMD_READ) && rd_ok_q) ? ram_rdata : 8'd0;
			skip_out_q <= (cmd_q == CMD_DRAW) && skip_q;
		end
	end

	assign read_data    = rdata_q;
	assign line_skipped = skip_out_q;

	always_comb begin
		stat.cmd       = cmd_q;
		stat.skip      = skip_q;
		stat.last      = cnt_q == 8'd0;
		stat.pipe_busy = valid_s1 || valid_s2;
		stat.clr_last  = clr_q == LAST_ADDR;
	end

endmodule

`default_nettype wire

### sv/line_rasterizer_to_page_buffer_unit.sv
// Line rasterizer into a monochrome page-organised frame buffer.
// Input stream: one beat per command. tuser carries the command (draw line, read
// byte, clear buffer); tdata carries the end points and the byte address.
// Output stream: exactly one beat per command, the byte read in tdata and the
// skipped-line flag in tuser; both are zero where the command does not set them.
// A draw that is not skipped walks one pixel per cycle through a read-modify-write
// pipeline on the single buffer memory. A clear sweeps the memory one byte a cycle.
// One command is worked on at a time; the next beat is taken once the result has
// gone to the output register, even while that result still waits. After reset
// the same clearing sweep runs and no input beat is taken until it ends. If the
// receiver stalls, the result is held and the block stops before loading the next
// result.
`default_nettype none

module line_rasterizer_to_page_buffer_unit #(
	parameter int DISPLAY_COLUMNS = lrpb_pkg::DISPLAY_COLUMNS_DEF,
	parameter int DISPLAY_ROWS    = lrpb_pkg::DISPLAY_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_x [7:0], start_y [15:8], end_x [23:16], end_y [31:24],
	// byte_address [41:32], zero [47:42]
	input  logic [47:0] s_axis_tdata,
	// command [1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data [7:0]
	output logic [7:0]  m_axis_tdata,
	// line_skipped [0]
	output logic        m_axis_tuser
);

	import lrpb_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	lrpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (dp_cmd),
		.stat     (dp_stat)
	);

	lrpb_datapath #(
		.DISPLAY_COLUMNS(DISPLAY_COLUMNS),
		.DISPLAY_ROWS   (DISPLAY_ROWS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.command     (s_axis_tuser),
		.start_x     (s_axis_tdata[7:0]),
		.start_y     (s_axis_tdata[15:8]),
		.end_x       (s_axis_tdata[23:16]),
		.end_y       (s_axis_tdata[31:24]),
		.byte_address(s_axis_tdata[41:32]),
		.read_data   (m_axis_tdata),
		.line_skipped(m_axis_tuser)
	);

endmodule

`default_nettype wire

### bench/line_rasterizer_to_page_buffer_unit_tb.sv
`timescale 1ns / 1ps

module line_rasterizer_to_page_buffer_unit_tb;
	import lrpb_pkg::*;

	localparam int COLUMNS      = DISPLAY_COLUMNS_DEF;
	localparam int ROWS         = DISPLAY_ROWS_DEF;
	localparam int BUFFER_BYTES = ((ROWS + PAGE_HEIGHT - 1) / PAGE_HEIGHT) * COLUMNS;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int STALL_LIMIT  = 20000;
	localparam int HOLD_CYCLES  = 900;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] start_x;
		logic [7:0] start_y;
		logic [7:0] end_x;
		logic [7:0] end_y;
		logic [9:0] byte_address;
	} line_cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       line_skipped;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;

	logic [7:0] page_image [BUFFER_BYTES] = '{default: 8'h00};
	line_cmd_t  commands_to_send [$];
	reply_t     replies_due [$];
	int         items_taken = 0;
	int         results_seen = 0;
	int         mismatches = 0;
	int         hold_left = 0;
	logic       hold_done = 1'b0;
	int         idle_cycles = 0;
	int         recent_x = 0;
	int         recent_y = 0;

	line_rasterizer_to_page_buffer_unit #(
		.DISPLAY_COLUMNS(COLUMNS),
		.DISPLAY_ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic void set_pixel(int x, int y);
		int idx;
		if (x < 0 || y < 0 || x >= COLUMNS || y >= ROWS)
			return;
		idx = (y / PAGE_HEIGHT) * COLUMNS + x;
		if (idx < BUFFER_BYTES)
			page_image[idx][y % PAGE_HEIGHT] = 1'b1;
	endfunction

	// Returns 1 when the start point lies beyond the display and nothing is drawn.
	function automatic logic trace_line(int x1, int y1, int x2, int y2);
		int dx, dy, sx, sy, major, minor, acc, x, y, i;
		logic x_major;
		if (x1 > COLUMNS || y1 > ROWS)
			return 1'b1;
		dx = x2 >= x1 ? x2 - x1 : x1 - x2;
		dy = y2 >= y1 ? y2 - y1 : y1 - y2;
		sx = x2 >= x1 ? 1 : -1;
		sy = y2 >= y1 ? 1 : -1;
		x_major = dx >= dy;
		major = x_major ? dx : dy;
		minor = x_major ? dy : dx;
		acc = major / 2;
		x = x1;
		y = y1;
		for (i = 0; i <= major; i++) begin
			set_pixel(x, y);
			acc += minor;
			if (acc >= major) begin
				acc -= major;
				if (x_major)
					y += sy;
				else
					x += sx;
			end
			if (x_major)
				x += sx;
			else
				y += sy;
		end
		return 1'b0;
	endfunction

	function automatic reply_t execute_command(line_cmd_t c);
		reply_t r;
		r = '0;
		case (c.command)
			CMD_DRAW: r.line_skipped = trace_line(c.start_x, c.start_y, c.end_x, c.end_y);
			CMD_READ: begin
				if (c.byte_address < BUFFER_BYTES)
					r.read_data = page_image[c.byte_address];
			end
			CMD_CLEAR: page_image = '{default: 8'h00};
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] nudge(int base);
		int v;
		v = base + int'($urandom_range(24)) - 12;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	function automatic line_cmd_t random_command();
		line_cmd_t c;
		int pick, shape;
		c.start_x = 8'($urandom);
		c.start_y = 8'($urandom);
		c.end_x = 8'($urandom);
		c.end_y = 8'($urandom);
		c.byte_address = 10'($urandom);
		pick = $urandom_range(99);
		if (pick < 2) begin
			c.command = CMD_CLEAR;
		end else if (pick < 5) begin
			c.command = CMD_SPARE;
		end else if (pick < 50) begin
			c.command = CMD_READ;
			// About half the reads land on the byte under a recent start point, when it is on the display.
			if (pick < 28 && recent_x < COLUMNS && recent_y < ROWS)
				c.byte_address = 10'((recent_y / PAGE_HEIGHT) * COLUMNS + recent_x);
		end else begin
			c.command = CMD_DRAW;
			shape = $urandom_range(9);
			if (shape >= 1) begin
				c.start_x = 8'($urandom_range(COLUMNS));
				c.start_y = 8'($urandom_range(ROWS));
			end
			if (shape >= 2) begin
				c.end_x = nudge(c.start_x);
				c.end_y = nudge(c.start_y);
			end
			recent_x = c.start_x;
			recent_y = c.start_y;
		end
		return c;
	endfunction

	task automatic queue_command(logic [1:0] command, int sx, int sy, int ex, int ey,
			int addr);
		line_cmd_t c;
		c.command = command;
		c.start_x = 8'(sx);
		c.start_y = 8'(sy);
		c.end_x = 8'(ex);
		c.end_y = 8'(ey);
		c.byte_address = 10'(addr);
		commands_to_send.push_back(c);
	endtask

	task automatic drain_and_refill(int count);
		wait (commands_to_send.size() == 0 && replies_due.size() == 0);
		@(negedge clk);
		repeat (count)
			commands_to_send.push_back(random_command());
	endtask

	// Sender: holds each beat until it is taken, and gaps at random between beats, but not while beats 1000 to 1299 go.
	always @(posedge clk or negedge arst_n) begin
		line_cmd_t head;
		logic offer;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				replies_due.push_back(execute_command(commands_to_send.pop_front()));
				items_taken <= items_taken + 1;
				offer = 1'b0;
			end
			if (!offer) begin
				if (commands_to_send.size() != 0 && ((items_taken >= 1000 &&
						items_taken < 1300) || $urandom_range(99) >= 25)) begin
					head = commands_to_send[0];
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'd0, head.byte_address, head.end_y, head.end_x,
						head.start_y, head.start_x};
					s_axis_tuser <= head.command;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result beat and stalls at random (not for results 1300 to 1599), once for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing expected: data %h skipped %b",
							$realtime, m_axis_tdata, m_axis_tuser);
				end else begin
					want = replies_due.pop_front();
					if (m_axis_tdata !== want.read_data ||
							m_axis_tuser !== want.line_skipped) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result %0d: data %h (expected %h), skipped %b (expected %b)",
								$realtime, results_seen, m_axis_tdata, want.read_data,
								m_axis_tuser, want.line_skipped);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && results_seen >= 400) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (results_seen >= 1300 && results_seen < 1600) ||
					$urandom_range(99) >= 25;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("line_rasterizer_to_page_buffer_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		queue_command(CMD_READ, 255, 255, 255, 255, 0);
		queue_command(CMD_DRAW, 0, 0, 127, 63, 0);
		queue_command(CMD_READ, 0, 0, 0, 0, 0);
		queue_command(CMD_DRAW, 127, 0, 0, 63, 0);
		// A start point on the width or the height is still drawn, then clipped.
		queue_command(CMD_DRAW, 128, 10, 100, 20, 0);
		queue_command(CMD_DRAW, 10, 64, 20, 40, 0);
		queue_command(CMD_DRAW, 129, 0, 0, 0, 0);
		queue_command(CMD_DRAW, 0, 65, 0, 0, 0);
		queue_command(CMD_DRAW, 255, 255, 0, 0, 1023);
		queue_command(CMD_DRAW, 0, 0, 255, 255, 0);
		queue_command(CMD_DRAW, 5, 5, 5, 5, 0);
		queue_command(CMD_DRAW, 3, 0, 3, 63, 0);
		queue_command(CMD_DRAW, 0, 7, 127, 7, 0);
		queue_command(CMD_DRAW, 60, 50, 0, 255, 0);
		queue_command(CMD_READ, 0, 0, 0, 0, 1023);
		queue_command(CMD_READ, 0, 0, 0, 0, 5);
		queue_command(CMD_READ, 0, 0, 0, 0, COLUMNS + 3);
		queue_command(CMD_SPARE, 255, 255, 255, 255, 1023);
		queue_command(CMD_READ, 0, 0, 0, 0, 7 * COLUMNS + 3);
		queue_command(CMD_CLEAR, 0, 0, 0, 0, 0);
		queue_command(CMD_READ, 0, 0, 0, 0, COLUMNS + 3);
		queue_command(CMD_READ, 0, 0, 0, 0, 0);
		drain_and_refill(600);
		drain_and_refill(550);
		drain_and_refill(550);
		wait (commands_to_send.size() == 0 && replies_due.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("line_rasterizer_to_page_buffer_unit regression: pass");
		else
			$display("line_rasterizer_to_page_buffer_unit regression: fail");
		$finish;
	end

endmodule

### line_rasterizer_to_page_buffer_unit.f
sv/lrpb_pkg.sv
sv/lrpb_ram.sv
sv/lrpb_ctrl.sv
sv/lrpb_datapath.sv
sv/line_rasterizer_to_page_buffer_unit.sv
bench/line_rasterizer_to_page_buffer_unit_tb.sv
